### hdl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared constants, command and status codes for the pooled free-list
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

    // Default geometry
    localparam int DEF_NUM_POOLS  = 4;
    localparam int DEF_POOL_SLOTS = 16;

    // Fixed field widths of the channels and the configuration register
    localparam int CMD_W    = 1;
    localparam int FPOOL_W  = 2;
    localparam int FSLOT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int POOL_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int LEFT_W   = 5;
    localparam int EPP_W    = 5;

    // Elements per pool after reset
    localparam logic [EPP_W-1:0] EPP_RESET = 5'd16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

endpackage : pfla_pkg

`default_nettype wire

### hdl/pfla_cmd_if.sv
// ----------------------------------------------------------------------------
// pfla_cmd_if / pfla_rsp_if
// Valid/ready channels for allocator commands and allocator responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_cmd_if import pfla_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FPOOL_W-1:0] free_pool;
    logic [FSLOT_W-1:0] free_slot;

    modport source (output valid, command, free_pool, free_slot, input ready);
    modport sink   (input valid, command, free_pool, free_slot, output ready);
endinterface : pfla_cmd_if

interface pfla_rsp_if import pfla_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POOL_W-1:0]   pool_index;
    logic [SLOT_W-1:0]   slot_index;
    logic [LEFT_W-1:0]   slots_left;

    modport source (output valid, status, pool_index, slot_index, slots_left, input ready);
    modport sink   (input valid, status, pool_index, slot_index, slots_left, output ready);
endinterface : pfla_rsp_if

`default_nettype wire

### hdl/pfla_link_ram.sv
// ----------------------------------------------------------------------------
// pfla_link_ram
// Slot link store: one write port and one read port with registered read
// data. Holds, per slot, the next slot of its pool's free list and a flag
// telling whether that link is present.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_link_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 5,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // Write and read the store; read data lands in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : pfla_link_ram

`default_nettype wire

### hdl/pooled_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// pooled_free_list_allocator_core
// Fixed-size slot allocator over up to NUM_POOLS pools with LIFO free lists.
// ----------------------------------------------------------------------------
// The block takes one command item per cycle unless a response stalls, and
// returns exactly one response item for it, registered, in the cycle after
// acceptance. An allocate serves the pool at the head of the available-pool
// list, creating the next pool when that list is empty; a free pushes the slot
// back on its pool's free list. The slot links live in a single-port-write,
// single-port-read store with registered read data. Each pool keeps its free-list
// head and the link of that head in flops; after a pop the link of the new head
// is fetched from the store and, when needed in the next cycle, taken straight
// from the store's read register, so back-to-back commands on the same pool keep
// that rate. The store needs no clearing after reset. elements_per_pool is
// sampled when a pool is created; 0 counts as 1 and values above POOL_SLOTS
// count as POOL_SLOTS. Write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pooled_free_list_allocator_core import pfla_pkg::*; #(
    parameter int NUM_POOLS  = DEF_NUM_POOLS,
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [EPP_W-1:0] cfg_wdata,
    pfla_cmd_if.sink              cmd,
    pfla_rsp_if.source            rsp
);

    localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int SW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW    = $clog2(POOL_SLOTS + 1);
    localparam int CRW   = $clog2(NUM_POOLS + 1);
    localparam int TOTAL = NUM_POOLS * POOL_SLOTS;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    // Configuration
    logic [EPP_W-1:0] epp_reg;
    logic [CW-1:0]    eff_size;

    // Pool state
    logic [CRW-1:0] created_reg, created_next;
    logic [CW-1:0]  fresh_reg   [NUM_POOLS];
    logic [CW-1:0]  fresh_next  [NUM_POOLS];
    logic [CW-1:0]  count_reg   [NUM_POOLS];
    logic [CW-1:0]  count_next  [NUM_POOLS];
    logic [SW-1:0]  head_reg    [NUM_POOLS];
    logic [SW-1:0]  head_next   [NUM_POOLS];
    logic           head_ok_reg [NUM_POOLS];
    logic           head_ok_next[NUM_POOLS];
    logic [SW-1:0]  cache_reg   [NUM_POOLS];
    logic [SW-1:0]  cache_next  [NUM_POOLS];
    logic           cache_ok_reg[NUM_POOLS];
    logic           cache_ok_next[NUM_POOLS];

    // Available-pool list
    logic [PW-1:0] alink_reg    [NUM_POOLS];
    logic [PW-1:0] alink_next   [NUM_POOLS];
    logic          alink_ok_reg [NUM_POOLS];
    logic          alink_ok_next[NUM_POOLS];
    logic [PW-1:0] ahead_reg, ahead_next;
    logic [PW-1:0] atail_reg, atail_next;
    logic          aany_reg, aany_next;

    // Outstanding link fetch
    logic          rd_pend_reg, rd_pend_next;
    logic [PW-1:0] rd_pool_reg, rd_pool_next;

    // Link store ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [SW:0]   rd_data;

    // Response register
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POOL_W-1:0]   pool_out_reg, pool_out_next;
    logic [SLOT_W-1:0]   slot_out_reg, slot_out_next;
    logic [LEFT_W-1:0]   left_out_reg, left_out_next;

    logic in_fire;

    function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] pool,
                                                input logic [SW-1:0] slot);
        slot_addr = AW'(AW'(pool) * AW'(POOL_SLOTS) + AW'(slot));
    endfunction

    // Accept while the response register is empty or being drained
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign in_fire   = cmd.valid && cmd.ready;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.pool_index = pool_out_reg;
    assign rsp.slot_index = slot_out_reg;
    assign rsp.slots_left = left_out_reg;

    // Clamp the pool size register
    always_comb
    begin
        priority if (epp_reg == '0)
        begin
            eff_size = CW'(1);
        end
        else if (32'(epp_reg) > POOL_SLOTS)
        begin
            eff_size = CW'(POOL_SLOTS);
        end
        else
        begin
            eff_size = CW'(epp_reg);
        end
    end

    // Execute one command item against the pool and list state
    always_comb
    begin
        logic [PW-1:0] pool;
        logic [SW-1:0] slot;
        logic          nospace;

        created_next  = created_reg;
        fresh_next    = fresh_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        head_ok_next  = head_ok_reg;
        alink_next    = alink_reg;
        alink_ok_next = alink_ok_reg;
        ahead_next    = ahead_reg;
        atail_next    = atail_reg;
        aany_next     = aany_reg;

        // Absorb a fetched link into its pool's head-link cache
        for (int q = 0; q < NUM_POOLS; q++)
        begin
            if (rd_pend_reg && rd_pool_reg == PW'(q))
            begin
                cache_next[q]    = rd_data[SW-1:0];
                cache_ok_next[q] = rd_data[SW];
            end
            else
            begin
                cache_next[q]    = cache_reg[q];
                cache_ok_next[q] = cache_ok_reg[q];
            end
        end

        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_pend_next = 1'b0;
        rd_pool_next = rd_pool_reg;

        pool    = '0;
        slot    = '0;
        nospace = 1'b0;

        status_next   = status_reg;
        pool_out_next = pool_out_reg;
        slot_out_next = slot_out_reg;
        left_out_next = left_out_reg;

        if (in_fire)
        begin
            unique case (cmd.command)
                CMD_ALLOC:
                begin
                    if (!aany_reg && 32'(created_reg) >= NUM_POOLS)
                    begin
                        nospace = 1'b1;
                    end
                    else
                    begin
                        // Create and append a new pool when none is available
                        if (!aany_reg)
                        begin
                            pool                = PW'(created_reg);
                            created_next        = CRW'(created_reg + 1'b1);
                            fresh_next[pool]    = '0;
                            count_next[pool]    = eff_size;
                            head_ok_next[pool]  = 1'b0;
                            alink_ok_next[pool] = 1'b0;
                            ahead_next          = pool;
                            atail_next          = pool;
                            aany_next           = 1'b1;
                        end
                        else
                        begin
                            pool = ahead_reg;
                        end

                        // Pop the free list, or hand out the next fresh slot
                        if (head_ok_next[pool])
                        begin
                            slot               = head_next[pool];
                            head_next[pool]    = cache_next[pool];
                            head_ok_next[pool] = cache_ok_next[pool];
                            if (cache_ok_next[pool])
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = slot_addr(pool, cache_next[pool]);
                                rd_pend_next = 1'b1;
                                rd_pool_next = pool;
                            end
                        end
                        else if (32'(fresh_next[pool]) >= POOL_SLOTS)
                        begin
                            nospace = 1'b1;
                        end
                        else
                        begin
                            slot             = SW'(fresh_next[pool]);
                            fresh_next[pool] = CW'(fresh_next[pool] + 1'b1);
                        end

                        // Count down; a pool with no free slot leaves the list
                        if (!nospace)
                        begin
                            if (count_next[pool] != '0)
                            begin
                                count_next[pool] = CW'(count_next[pool] - 1'b1);
                            end
                            if (count_next[pool] == '0)
                            begin
                                if (alink_ok_next[pool])
                                begin
                                    ahead_next = alink_next[pool];
                                end
                                else
                                begin
                                    aany_next = 1'b0;
                                end
                                alink_ok_next[pool] = 1'b0;
                            end
                        end
                    end

                    if (nospace)
                    begin
                        status_next   = ST_NOSPACE;
                        pool_out_next = '0;
                        slot_out_next = '0;
                        left_out_next = '0;
                    end
                    else
                    begin
                        status_next   = ST_ALLOC;
                        pool_out_next = POOL_W'(pool);
                        slot_out_next = SLOT_W'(slot);
                        left_out_next = LEFT_W'(count_next[pool]);
                    end
                end

                CMD_FREE:
                begin
                    pool          = PW'(cmd.free_pool);
                    slot          = SW'(cmd.free_slot);
                    status_next   = ST_FREED;
                    pool_out_next = cmd.free_pool;
                    slot_out_next = cmd.free_slot;

                    if (32'(cmd.free_pool) >= 32'(created_reg))
                    begin
                        // Pool not created: report and drop
                        left_out_next = '0;
                    end
                    else if (32'(cmd.free_slot) >= POOL_SLOTS)
                    begin
                        // Slot out of range: report and drop
                        left_out_next = LEFT_W'(count_reg[pool]);
                    end
                    else
                    begin
                        // Push the slot on its pool's free list
                        wr_en               = 1'b1;
                        wr_addr             = slot_addr(pool, slot);
                        wr_data             = {head_ok_reg[pool], head_reg[pool]};
                        cache_next[pool]    = head_reg[pool];
                        cache_ok_next[pool] = head_ok_reg[pool];
                        head_next[pool]     = slot;
                        head_ok_next[pool]  = 1'b1;

                        // Count up; a pool regaining its first slot joins the list
                        if (32'(count_reg[pool]) < POOL_SLOTS)
                        begin
                            count_next[pool] = CW'(count_reg[pool] + 1'b1);
                            if (count_next[pool] == CW'(1))
                            begin
                                alink_ok_next[pool] = 1'b0;
                                if (!aany_reg)
                                begin
                                    ahead_next = pool;
                                    atail_next = pool;
                                    aany_next  = 1'b1;
                                end
                                else
                                begin
                                    alink_next[atail_reg]    = pool;
                                    alink_ok_next[atail_reg] = 1'b1;
                                    atail_next               = pool;
                                end
                            end
                        end
                        left_out_next = LEFT_W'(count_next[pool]);
                    end
                end

                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epp_reg       <= EPP_RESET;
            created_reg   <= '0;
            aany_reg      <= 1'b0;
            ahead_reg     <= '0;
            atail_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            rd_pool_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int q = 0; q < NUM_POOLS; q++)
            begin
                fresh_reg[q]    <= '0;
                count_reg[q]    <= '0;
                head_ok_reg[q]  <= 1'b0;
                cache_ok_reg[q] <= 1'b0;
                alink_ok_reg[q] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                epp_reg <= cfg_wdata;
            end
            created_reg  <= created_next;
            aany_reg     <= aany_next;
            ahead_reg    <= ahead_next;
            atail_reg    <= atail_next;
            rd_pend_reg  <= rd_pend_next;
            rd_pool_reg  <= rd_pool_next;
            fresh_reg    <= fresh_next;
            count_reg    <= count_next;
            head_ok_reg  <= head_ok_next;
            cache_ok_reg <= cache_ok_next;
            alink_ok_reg <= alink_ok_next;
            if (in_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        cache_reg    <= cache_next;
        alink_reg    <= alink_next;
        status_reg   <= status_next;
        pool_out_reg <= pool_out_next;
        slot_out_reg <= slot_out_next;
        left_out_reg <= left_out_next;
    end

    pfla_link_ram #(
        .DEPTH (TOTAL),
        .DW    (SW + 1),
        .AW    (AW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule : pooled_free_list_allocator_core

`default_nettype wire

### hdl/pfla_checker.sv
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level checks on the allocator: response timing, response hold and
// response field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_checker import pfla_pkg::*; #(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cmd_valid,
    input wire logic                cmd_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [POOL_W-1:0]   pool_index,
    input wire logic [SLOT_W-1:0]   slot_index,
    input wire logic [LEFT_W-1:0]   slots_left
);

    // Every accepted item yields a response in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid)
        else $error("accepted item produced no response");

    // A stalled response holds its fields
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
        $stable(pool_index) && $stable(slot_index) && $stable(slots_left))
        else $error("stalled response changed");

    // No-space responses carry zeroed fields
    a_nospace_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_NOSPACE |->
        pool_index == '0 && slot_index == '0 && slots_left == '0)
        else $error("no-space response with nonzero fields");

    // An allocation always leaves fewer than a full pool free
    a_alloc_left: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_ALLOC |-> 32'(slots_left) < POOL_SLOTS)
        else $error("allocation left a full pool free");

endmodule : pfla_checker

bind pooled_free_list_allocator_core pfla_checker #(
    .POOL_SLOTS (POOL_SLOTS)
) u_pfla_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .pool_index (rsp.pool_index),
    .slot_index (rsp.slot_index),
    .slots_left (rsp.slots_left)
);

`default_nettype wire

### verif/pooled_free_list_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// pooled_free_list_allocator_core_tb
// Self-checking bench for the pooled free-list allocator. Commands go in over
// the valid/ready command channel with bursty timing while the response side
// stalls on its own pattern. A cycle-free model of the pools, free lists and
// the available-pool list predicts every response, which is then checked field
// by field in order. Directed items cover the smallest and largest pool
// sizes, LIFO reuse and frees of unknown pools. The random part mixes
// well-formed allocate/free traffic with stray frees and rare free floods.
// ----------------------------------------------------------------------------
module pooled_free_list_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfla_pkg::*;

    localparam int NPOOLS       = DEF_NUM_POOLS;
    localparam int NSLOTS       = DEF_POOL_SLOTS;
    localparam int RANDOM_ITEMS = 1900;
    localparam int FLOOD_LEN    = NSLOTS + 1;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POOL_W-1:0]   pool_index;
        logic [SLOT_W-1:0]   slot_index;
        logic [LEFT_W-1:0]   slots_left;
    } alloc_rsp_t;

    typedef struct packed {
        logic [FPOOL_W-1:0] pool;
        logic [FSLOT_W-1:0] slot;
    } slot_ref_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [EPP_W-1:0] cfg_wdata;

    pfla_cmd_if cmd_bus ();
    pfla_rsp_if rsp_bus ();

    pooled_free_list_allocator_core #(
        .NUM_POOLS  (NPOOLS),
        .POOL_SLOTS (NSLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus)
    );

    // Allocator state as the bench sees it
    logic [SLOT_W-1:0] chain_of     [NPOOLS*NSLOTS];
    bit                chain_ok     [NPOOLS*NSLOTS];
    logic [SLOT_W-1:0] stack_top    [NPOOLS];
    bit                stack_top_ok [NPOOLS];
    logic [LEFT_W-1:0] unused_next  [NPOOLS];
    logic [LEFT_W-1:0] spare_cnt    [NPOOLS];
    logic [POOL_W-1:0] open_next    [NPOOLS];
    bit                open_next_ok [NPOOLS];
    logic [POOL_W-1:0] open_first;
    logic [POOL_W-1:0] open_last;
    bit                open_any;
    int                pools_built;
    logic [EPP_W-1:0]  pool_size_reg;

    alloc_rsp_t expected_rsp [$];
    slot_ref_t  held_slots [$];
    alloc_rsp_t seen_rsp;
    alloc_rsp_t due_rsp;
    int         mismatches;
    int         items_sent;
    int         burst_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #5_000_000;
        $display("FAIL pooled_free_list_allocator_core");
        $finish;
    end

    // Append a pool to the tail of the open-pool list
    function automatic void open_append(input int p);
        open_next_ok[p] = 1'b0;
        if (!open_any)
        begin
            open_first = POOL_W'(p);
            open_last  = POOL_W'(p);
            open_any   = 1'b1;
        end
        else
        begin
            open_next[open_last]    = POOL_W'(p);
            open_next_ok[open_last] = 1'b1;
            open_last               = POOL_W'(p);
        end
    endfunction

    // Advance the allocator state by one command and return its response
    function automatic alloc_rsp_t predict_response(input logic [CMD_W-1:0] c,
                                                    input logic [FPOOL_W-1:0] fp,
                                                    input logic [FSLOT_W-1:0] fs);
        alloc_rsp_t r;
        int         p;
        int         s;
        int         idx;
        int         size;
        r = '{ST_NOSPACE, '0, '0, '0};
        if (c == CMD_ALLOC)
        begin
            // create the next pool when nothing is open
            if (!open_any)
            begin
                if (pools_built >= NPOOLS)
                    return r;
                p = pools_built;
                pools_built++;
                size = (pool_size_reg == 0) ? 1 :
                       (pool_size_reg > NSLOTS) ? NSLOTS : pool_size_reg;
                unused_next[p]  = '0;
                spare_cnt[p]    = LEFT_W'(size);
                stack_top_ok[p] = 1'b0;
                open_append(p);
            end
            p = open_first;
            // pop the free list, else hand out the next fresh slot
            if (stack_top_ok[p])
            begin
                s   = stack_top[p];
                idx = p * NSLOTS + s;
                if (chain_ok[idx])
                    stack_top[p] = chain_of[idx];
                else
                    stack_top_ok[p] = 1'b0;
            end
            else
            begin
                s = unused_next[p];
                if (s >= NSLOTS)
                    return r;
                unused_next[p] = LEFT_W'(s + 1);
            end
            if (spare_cnt[p] > 0)
                spare_cnt[p]--;
            // drop a pool with no spare slot from the open list
            if (spare_cnt[p] == 0)
            begin
                if (open_next_ok[p])
                    open_first = open_next[p];
                else
                    open_any = 1'b0;
                open_next_ok[p] = 1'b0;
            end
            r = '{ST_ALLOC, p[POOL_W-1:0], s[SLOT_W-1:0], spare_cnt[p]};
            return r;
        end
        p = fp;
        s = fs;
        r = '{ST_FREED, fp, fs, '0};
        if (p >= pools_built)
            return r;
        // push the slot, count up to the pool limit
        idx             = p * NSLOTS + s;
        chain_of[idx]   = stack_top[p];
        chain_ok[idx]   = stack_top_ok[p];
        stack_top[p]    = fs;
        stack_top_ok[p] = 1'b1;
        if (spare_cnt[p] < NSLOTS)
        begin
            spare_cnt[p]++;
            if (spare_cnt[p] == 1)
                open_append(p);
        end
        r.slots_left = spare_cnt[p];
        return r;
    endfunction

    // Send one command item, idling between bursts, and predict its response
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [FPOOL_W-1:0] fp,
                            input logic [FSLOT_W-1:0] fs);
        alloc_rsp_t want;
        if (burst_left == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.command   <= c;
        cmd_bus.free_pool <= fp;
        cmd_bus.free_slot <= fs;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        burst_left--;
        items_sent++;
        want = predict_response(c, fp, fs);
        expected_rsp.push_back(want);
        // track slots held by the caller
        if (want.status == ST_ALLOC)
            held_slots.push_back('{want.pool_index, want.slot_index});
        else if (c == CMD_FREE)
        begin
            for (int k = 0; k < held_slots.size(); k++)
            begin
                if (held_slots[k].pool == fp && held_slots[k].slot == fs)
                begin
                    held_slots.delete(k);
                    break;
                end
            end
        end
    endtask

    // Hold off commands until every response has come back
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp.size() != 0);
    endtask

    // Write elements_per_pool
    task automatic write_epp(input logic [EPP_W-1:0] v);
        cfg_we        <= 1'b1;
        cfg_wdata     <= v;
        pool_size_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Size zero counts as one slot: take it, give it back, free an unknown pool, reuse it
    task automatic test_smallest_pool();
        write_epp(5'd0);
        send_cmd(CMD_ALLOC, 2'd0, 4'd0);
        send_cmd(CMD_FREE, 2'd0, 4'd0);
        send_cmd(CMD_FREE, 2'd3, 4'd15);
        send_cmd(CMD_ALLOC, 2'd3, 4'd15);
    endtask

    // Oversize register counts as a full pool: drain it, then check LIFO reuse
    task automatic test_largest_pool();
        wait_idle();
        write_epp(5'd31);
        repeat (NSLOTS) send_cmd(CMD_ALLOC, 2'd0, 4'd0);
        send_cmd(CMD_FREE, 2'd1, 4'd15);
        send_cmd(CMD_FREE, 2'd1, 4'd3);
        repeat (2) send_cmd(CMD_ALLOC, 2'd0, 4'd0);
    endtask

    // Mostly balanced alloc/free traffic, with stray frees and free floods
    task automatic test_random_traffic();
        int        stop_at;
        int        fill_pct;
        int        pick;
        int        fp;
        bit        last_pool_sized;
        slot_ref_t victim;
        stop_at         = items_sent + RANDOM_ITEMS;
        fill_pct        = 85;
        last_pool_sized = 1'b0;
        wait_idle();
        write_epp(5'd16);
        while (items_sent < stop_at)
        begin
            // size the last pool once the third one exists
            if (pools_built == NPOOLS - 1 && !last_pool_sized)
            begin
                wait_idle();
                write_epp(5'd1);
                last_pool_sized = 1'b1;
            end
            if ($urandom_range(0, 99) == 0)
                fill_pct = $urandom_range(0, 1) ? $urandom_range(75, 95)
                                                : $urandom_range(15, 40);
            pick = $urandom_range(0, 999);
            if (pick < 4 && pools_built > 0)
            begin
                fp = $urandom_range(0, pools_built - 1);
                repeat (FLOOD_LEN)
                    send_cmd(CMD_FREE, FPOOL_W'(fp),
                             FSLOT_W'($urandom_range(0, NSLOTS - 1)));
            end
            else if (pick < 60)
                send_cmd(CMD_FREE, FPOOL_W'($urandom_range(0, 3)),
                         FSLOT_W'($urandom_range(0, 15)));
            else if (held_slots.size() == 0 || $urandom_range(0, 99) < fill_pct)
                send_cmd(CMD_ALLOC, FPOOL_W'($urandom), FSLOT_W'($urandom));
            else
            begin
                victim = held_slots[$urandom_range(0, held_slots.size() - 1)];
                send_cmd(CMD_FREE, victim.pool, victim.slot);
            end
        end
    endtask

    // Response side: stall on one of four randomly chosen patterns
    initial
    begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: rsp_bus.ready <= 1'b1;
                1: rsp_bus.ready <= ($urandom_range(0, 9) < 7);
                2: rsp_bus.ready <= ((cyc % 8) < 2);
                default: rsp_bus.ready <= ((cyc % 11) != 0);
            endcase
        end
    end

    // Check each response against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            seen_rsp = {rsp_bus.status, rsp_bus.pool_index,
                        rsp_bus.slot_index, rsp_bus.slots_left};
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response with none pending: status %0d pool %0d slot %0d left %0d",
                             $realtime, seen_rsp.status, seen_rsp.pool_index,
                             seen_rsp.slot_index, seen_rsp.slots_left);
            end
            else
            begin
                due_rsp = expected_rsp.pop_front();
                if (seen_rsp.status !== due_rsp.status
                    || seen_rsp.pool_index !== due_rsp.pool_index
                    || seen_rsp.slot_index !== due_rsp.slot_index
                    || seen_rsp.slots_left !== due_rsp.slots_left)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("%0t: mismatch exp status %0d pool %0d slot %0d left %0d",
                               $realtime, due_rsp.status, due_rsp.pool_index,
                               due_rsp.slot_index, due_rsp.slots_left);
                        $display(" / got status %0d pool %0d slot %0d left %0d",
                                 seen_rsp.status, seen_rsp.pool_index,
                                 seen_rsp.slot_index, seen_rsp.slots_left);
                    end
                end
            end
        end
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.command   <= CMD_ALLOC;
        cmd_bus.free_pool <= '0;
        cmd_bus.free_slot <= '0;
        for (int i = 0; i < NPOOLS * NSLOTS; i++)
        begin
            chain_of[i] = '0;
            chain_ok[i] = 1'b0;
        end
        for (int i = 0; i < NPOOLS; i++)
        begin
            stack_top[i]    = '0;
            stack_top_ok[i] = 1'b0;
            unused_next[i]  = '0;
            spare_cnt[i]    = '0;
            open_next[i]    = '0;
            open_next_ok[i] = 1'b0;
        end
        open_first    = '0;
        open_last     = '0;
        open_any      = 1'b0;
        pools_built   = 0;
        pool_size_reg = EPP_RESET;
        mismatches    = 0;
        items_sent    = 0;
        burst_left    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_smallest_pool();
        test_largest_pool();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS pooled_free_list_allocator_core");
        else
            $display("FAIL pooled_free_list_allocator_core");
        $finish;
    end

endmodule

### pooled_free_list_allocator_core.f
hdl/pfla_pkg.sv
hdl/pfla_cmd_if.sv
hdl/pfla_link_ram.sv
hdl/pooled_free_list_allocator_core.sv
hdl/pfla_checker.sv
verif/pooled_free_list_allocator_core_tb.sv
